// ===== sv/spce_pkg.sv =====
// Shared types and constants for the shortest-path counting engine.
package spce_pkg;

	localparam int unsigned VID_W      = 10;
	localparam int unsigned CFG_W      = 11;
	localparam int unsigned ARC_COST_W = 14;
	localparam int unsigned OUT_COST_W = 24;
	localparam int unsigned WAYS_W     = 32;
	localparam int unsigned LIM_W      = 16;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_ADD   = 2'd1,
		OP_QUERY = 2'd2
	} op_t;

	typedef enum logic [4:0] {
		S_IDLE, S_SWEEP, S_SEED, S_POP_RD0, S_POP_RDL, S_POP_FIX,
		S_SD_L, S_SD_LW, S_SD_RW, S_SD_MOVE, S_U_RD, S_U_CHK,
		S_E_RD, S_E_CHK, S_V_UPD, S_SU_RD, S_SU_CHK, S_DONE
	} state_t;

	typedef enum logic [4:0] {
		C_NONE, C_CLEAR, C_ADD, C_QLOAD, C_SWEEP, C_SEED, C_POP_RD0, C_POP_RDL,
		C_POP_FIX, C_SD_L, C_SD_LW, C_SD_RW, C_SD_MOVE, C_U_RD, C_U_CHK,
		C_E_RD, C_E_CHK, C_V_UPD, C_SU_RD, C_SU_CHK
	} dp_cmd_t;

	typedef struct packed {
		logic q_bad;
		logic sweep_last;
		logic heap_empty;
		logic sd_leaf;
		logic has_r;
		logic sd_stop;
		logic u_settled;
		logic u_is_end;
		logic edges_done;
		logic arc_follow;
		logic push_go;
		logic su_root;
		logic su_up;
	} dp_status_t;

endpackage

// ===== sv/spce_ctrl.sv =====
// Sequencing state machine for the shortest-path counting engine.
module spce_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [1:0]            op,
	input  spce_pkg::dp_status_t  status,
	output spce_pkg::dp_cmd_t     cmd,
	output logic                  busy,
	output logic                  done
);
	import spce_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = C_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (op)
						OP_CLEAR: cmd = C_CLEAR;
						OP_ADD:   cmd = C_ADD;
						OP_QUERY: begin
							cmd     = C_QLOAD;
							state_d = status.q_bad ? S_DONE : S_SWEEP;
						end
						default: cmd = C_NONE;
					endcase
				end
			end
			S_SWEEP: begin
				cmd = C_SWEEP;
				if (status.sweep_last) state_d = S_SEED;
			end
			S_SEED: begin
				cmd     = C_SEED;
				state_d = S_POP_RD0;
			end
			S_POP_RD0: begin
				if (status.heap_empty) begin
					state_d = S_DONE;
				end else begin
					cmd     = C_POP_RD0;
					state_d = S_POP_RDL;
				end
			end
			S_POP_RDL: begin
				cmd     = C_POP_RDL;
				state_d = S_POP_FIX;
			end
			S_POP_FIX: begin
				cmd     = C_POP_FIX;
				state_d = S_SD_L;
			end
			S_SD_L: begin
				cmd     = C_SD_L;
				state_d = status.sd_leaf ? S_U_RD : S_SD_LW;
			end
			S_SD_LW: begin
				cmd     = C_SD_LW;
				state_d = status.has_r ? S_SD_RW : S_SD_MOVE;
			end
			S_SD_RW: begin
				cmd     = C_SD_RW;
				state_d = S_SD_MOVE;
			end
			S_SD_MOVE: begin
				cmd     = C_SD_MOVE;
				state_d = status.sd_stop ? S_U_RD : S_SD_L;
			end
			S_U_RD: begin
				cmd     = C_U_RD;
				state_d = S_U_CHK;
			end
			S_U_CHK: begin
				cmd = C_U_CHK;
				if (status.u_settled) begin
					state_d = S_POP_RD0;
				end else if (status.u_is_end) begin
					state_d = S_DONE;
				end else begin
					state_d = S_E_RD;
				end
			end
			S_E_RD: begin
				cmd     = C_E_RD;
				state_d = status.edges_done ? S_POP_RD0 : S_E_CHK;
			end
			S_E_CHK: begin
				cmd     = C_E_CHK;
				state_d = status.arc_follow ? S_V_UPD : S_E_RD;
			end
			S_V_UPD: begin
				cmd     = C_V_UPD;
				state_d = status.push_go ? S_SU_RD : S_E_RD;
			end
			S_SU_RD: begin
				cmd     = C_SU_RD;
				state_d = status.su_root ? S_E_RD : S_SU_CHK;
			end
			S_SU_CHK: begin
				cmd     = C_SU_CHK;
				state_d = status.su_up ? S_SU_RD : S_E_RD;
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

endmodule

// ===== sv/spce_dp.sv =====
// Datapath: arc store, per-vertex search memory, frontier heap and result registers.
module spce_dp #(
	parameter int unsigned MAX_VERTICES = 1024,
	parameter int unsigned MAX_ARCS     = 4096,
	parameter int unsigned COST_BITS    = 14
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  spce_pkg::dp_cmd_t                  cmd,
	output spce_pkg::dp_status_t               status,
	input  logic                               cfg_we,
	input  logic [spce_pkg::CFG_W-1:0]         cfg_data,
	input  logic [spce_pkg::VID_W-1:0]         arc_from,
	input  logic [spce_pkg::VID_W-1:0]         arc_to,
	input  logic [spce_pkg::ARC_COST_W-1:0]    arc_cost,
	input  logic [spce_pkg::VID_W-1:0]         query_from,
	input  logic [spce_pkg::VID_W-1:0]         query_to,
	output logic                               path_found,
	output logic [spce_pkg::OUT_COST_W-1:0]    min_cost,
	output logic [spce_pkg::WAYS_W-1:0]        way_count,
	output logic                               arc_overflow
);
	import spce_pkg::*;

	localparam int unsigned VIW    = $clog2(MAX_VERTICES);
	localparam int unsigned EIW    = (MAX_ARCS > 1) ? $clog2(MAX_ARCS) : 1;
	localparam int unsigned EFW    = $clog2(MAX_ARCS + 1);
	localparam int unsigned HDEPTH = MAX_ARCS + 1;
	localparam int unsigned HIW    = $clog2(HDEPTH);
	localparam int unsigned HFW    = $clog2(HDEPTH + 1);
	localparam int unsigned CW     = COST_BITS + VIW;

	typedef struct packed {
		logic [CW-1:0]    cost;
		logic [VID_W-1:0] vtx;
	} hent_t;

	typedef struct packed {
		logic              settled;
		logic              reached;
		logic [CW-1:0]     cost;
		logic [WAYS_W-1:0] ways;
	} vent_t;

	typedef struct packed {
		logic [VID_W-1:0]     src;
		logic [VID_W-1:0]     tgt;
		logic [COST_BITS-1:0] w;
	} arc_t;

	function automatic logic ent_less(hent_t a, hent_t b);
		return (a.cost < b.cost) || ((a.cost == b.cost) && (a.vtx < b.vtx));
	endfunction

	// Control registers.
	logic [CFG_W-1:0] nv_q;
	logic [EFW-1:0]   total_q;
	logic             ovf_q;
	logic [HFW-1:0]   fill_q;

	// Working registers.
	logic [VID_W-1:0]     qfrom_q, qto_q, u_q, v_q;
	logic [LIM_W-1:0]     swc_q;
	logic [HIW-1:0]       i_q, m_q;
	hent_t                cur_q, mval_q;
	logic [CW-1:0]        ucost_q;
	logic [WAYS_W-1:0]    uways_q;
	logic [EFW-1:0]       e_q;
	logic [COST_BITS-1:0] w_q;
	logic                 res_found_q, res_ovf_q;
	logic [OUT_COST_W-1:0] res_cost_q;
	logic [WAYS_W-1:0]    res_ways_q;

	// Memories.
	arc_t  arc_mem [MAX_ARCS];
	vent_t vmem [MAX_VERTICES];
	hent_t hmem [HDEPTH];
	arc_t  arc_rd;
	vent_t vrd;
	hent_t hrd;

	logic            arc_we;
	logic            vwe;
	logic [VIW-1:0]  vwa, vra;
	vent_t           vwd;
	logic            hwe;
	logic [HIW-1:0]  hwa, hra;
	hent_t           hwd;

	// Derived values.
	logic [LIM_W-1:0]             nv_ext, n_lim;
	logic [HIW+1:0]               l_idx, r_idx, fill_x;
	logic [HIW-1:0]               im1, p_idx;
	logic [CW-1:0]                nc;
	logic                         improve, equal, push_go;
	logic [WAYS_W:0]              ways_sum;
	logic [WAYS_W-1:0]            ways_sat;
	logic [CW+OUT_COST_W-1:0]     cost_ext;
	logic [OUT_COST_W-1:0]        cost_sat;
	logic                         arc_full, heap_full;

	always_comb begin
		nv_ext = LIM_W'(nv_q);
		if (nv_ext == '0) begin
			n_lim = LIM_W'(1);
		end else if (nv_ext > LIM_W'(MAX_VERTICES)) begin
			n_lim = LIM_W'(MAX_VERTICES);
		end else begin
			n_lim = nv_ext;
		end
	end

	assign l_idx     = {1'b0, i_q, 1'b1};
	assign r_idx     = l_idx + (HIW+2)'(1);
	assign fill_x    = (HIW+2)'(fill_q);
	assign im1       = i_q - HIW'(1);
	assign p_idx     = im1 >> 1;
	assign nc        = ucost_q + CW'(w_q);
	assign improve   = !vrd.reached || (vrd.cost > nc);
	assign equal     = vrd.reached && (vrd.cost == nc);
	assign ways_sum  = {1'b0, vrd.ways} + {1'b0, uways_q};
	assign ways_sat  = ways_sum[WAYS_W] ? '1 : ways_sum[WAYS_W-1:0];
	assign cost_ext  = {OUT_COST_W'(0), vrd.cost};
	assign cost_sat  = (|cost_ext[CW+OUT_COST_W-1:OUT_COST_W]) ? '1 :
		cost_ext[OUT_COST_W-1:0];
	assign arc_full  = (total_q == EFW'(MAX_ARCS));
	assign heap_full = (fill_q == HFW'(HDEPTH));
	assign push_go   = improve && !heap_full;

	always_comb begin
		status.q_bad      = (LIM_W'(query_from) >= n_lim) || (LIM_W'(query_to) >= n_lim);
		status.sweep_last = (swc_q == n_lim - LIM_W'(1));
		status.heap_empty = (fill_q == '0);
		status.sd_leaf    = (l_idx >= fill_x);
		status.has_r      = (r_idx < fill_x);
		status.sd_stop    = (m_q == i_q);
		status.u_settled  = vrd.settled;
		status.u_is_end   = (u_q == qto_q);
		status.edges_done = (e_q == total_q);
		status.arc_follow = (arc_rd.src == u_q) && (LIM_W'(arc_rd.tgt) < n_lim);
		status.push_go    = push_go;
		status.su_root    = (i_q == '0);
		status.su_up      = ent_less(cur_q, hrd);
	end

	// Memory port control.
	always_comb begin
		arc_we = 1'b0;
		vwe    = 1'b0;
		vwa    = '0;
		vwd    = '0;
		vra    = '0;
		hwe    = 1'b0;
		hwa    = '0;
		hwd    = cur_q;
		hra    = '0;
		unique case (cmd)
			C_ADD: arc_we = !arc_full;
			C_SWEEP: begin
				vwe = 1'b1;
				vwa = VIW'(swc_q);
			end
			C_SEED: begin
				vwe         = 1'b1;
				vwa         = VIW'(qfrom_q);
				vwd.reached = 1'b1;
				vwd.ways    = WAYS_W'(1);
				hwe         = 1'b1;
				hwd.cost    = '0;
				hwd.vtx     = qfrom_q;
			end
			C_POP_RDL: hra = HIW'(fill_q - HFW'(1));
			C_SD_L: begin
				if (status.sd_leaf) begin
					hwe = 1'b1;
					hwa = i_q;
				end else begin
					hra = HIW'(l_idx);
				end
			end
			C_SD_LW: hra = HIW'(r_idx);
			C_SD_MOVE: begin
				hwe = 1'b1;
				hwa = i_q;
				hwd = (m_q == i_q) ? cur_q : mval_q;
			end
			C_U_RD: vra = VIW'(u_q);
			C_U_CHK: begin
				vwe         = !vrd.settled;
				vwa         = VIW'(u_q);
				vwd         = vrd;
				vwd.settled = 1'b1;
			end
			C_E_CHK: vra = VIW'(arc_rd.tgt);
			C_V_UPD: begin
				vwe         = improve || equal;
				vwa         = VIW'(v_q);
				vwd.settled = vrd.settled;
				vwd.reached = 1'b1;
				vwd.cost    = improve ? nc : vrd.cost;
				vwd.ways    = improve ? uways_q : ways_sat;
			end
			C_SU_RD: begin
				if (i_q == '0) begin
					hwe = 1'b1;
				end else begin
					hra = p_idx;
				end
			end
			C_SU_CHK: begin
				hwe = 1'b1;
				hwa = i_q;
				hwd = status.su_up ? hrd : cur_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (arc_we) begin
			arc_mem[EIW'(total_q)] <= '{src: arc_from, tgt: arc_to,
				w: COST_BITS'(arc_cost)};
		end
		arc_rd <= arc_mem[EIW'(e_q)];
	end

	always_ff @(posedge clk) begin
		if (vwe) begin
			vmem[vwa] <= vwd;
		end
		vrd <= vmem[vra];
	end

	always_ff @(posedge clk) begin
		if (hwe) begin
			hmem[hwa] <= hwd;
		end
		hrd <= hmem[hra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nv_q    <= CFG_W'(1);
			total_q <= '0;
			ovf_q   <= 1'b0;
			fill_q  <= '0;
		end else begin
			if (cfg_we) nv_q <= cfg_data;
			unique case (cmd)
				C_CLEAR: begin
					total_q <= '0;
					ovf_q   <= 1'b0;
				end
				C_ADD: begin
					if (arc_full) begin
						ovf_q <= 1'b1;
					end else begin
						total_q <= total_q + EFW'(1);
					end
				end
				C_SEED:    fill_q <= HFW'(1);
				C_POP_FIX: fill_q <= fill_q - HFW'(1);
				C_V_UPD:   if (push_go) fill_q <= fill_q + HFW'(1);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd)
			C_QLOAD: begin
				qfrom_q     <= query_from;
				qto_q       <= query_to;
				swc_q       <= '0;
				res_found_q <= 1'b0;
				res_cost_q  <= '0;
				res_ways_q  <= '0;
				res_ovf_q   <= ovf_q;
			end
			C_SWEEP:   swc_q <= swc_q + LIM_W'(1);
			C_POP_RDL: u_q <= hrd.vtx;
			C_POP_FIX: begin
				cur_q <= hrd;
				i_q   <= '0;
			end
			C_SD_LW: begin
				if (ent_less(hrd, cur_q)) begin
					m_q    <= HIW'(l_idx);
					mval_q <= hrd;
				end else begin
					m_q    <= i_q;
					mval_q <= cur_q;
				end
			end
			C_SD_RW: begin
				if (ent_less(hrd, mval_q)) begin
					m_q    <= HIW'(r_idx);
					mval_q <= hrd;
				end
			end
			C_SD_MOVE: if (m_q != i_q) i_q <= m_q;
			C_U_CHK: begin
				if (!vrd.settled) begin
					if (u_q == qto_q) begin
						res_found_q <= 1'b1;
						res_cost_q  <= cost_sat;
						res_ways_q  <= vrd.ways;
					end else begin
						ucost_q <= vrd.cost;
						uways_q <= vrd.ways;
						e_q     <= '0;
					end
				end
			end
			C_E_CHK: begin
				v_q <= arc_rd.tgt;
				w_q <= arc_rd.w;
				if (!status.arc_follow) e_q <= e_q + EFW'(1);
			end
			C_V_UPD: begin
				e_q <= e_q + EFW'(1);
				// A zero-cost self loop adds to the ways of the vertex being expanded.
				if ((v_q == u_q) && equal) uways_q <= ways_sat;
				if (push_go) begin
					cur_q.cost <= nc;
					cur_q.vtx  <= v_q;
					i_q        <= HIW'(fill_q);
				end
			end
			C_SU_CHK: if (status.su_up) i_q <= p_idx;
			default: ;
		endcase
	end

	assign path_found   = res_found_q;
	assign min_cost     = res_cost_q;
	assign way_count    = res_ways_q;
	assign arc_overflow = res_ovf_q;

endmodule

// ===== sv/shortest_path_count_engine.sv =====
// Top level of the shortest-path counting engine.
//
//  channel   | signals                                         | handshake
//  ----------+-------------------------------------------------+----------------------
//  request   | op, arc_from, arc_to, arc_cost, query_from/to   | start && !busy
//  result    | path_found, min_cost, way_count, arc_overflow   | done, one cycle
//  config    | cfg_data (num_vertices)                         | cfg_valid && cfg_ready
//
// Clear and add-arc requests leave busy low and may follow each other in every cycle.
// A query keeps busy high while it sweeps the vertex memory clear, then pops the heap,
// scans the stored arcs for each expanded vertex, relaxes the arcs it follows and sifts
// each push up the heap. A query naming a vertex out of range skips the search and
// goes straight to done. Reset clears the arc count and the flags; the memories
// need no clearing pass. The receiver cannot stall: done marks each result for
// exactly one cycle.
module shortest_path_count_engine #(
	parameter int unsigned MAX_VERTICES = 1024,
	parameter int unsigned MAX_ARCS     = 4096,
	parameter int unsigned COST_BITS    = 14
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [1:0]                         op,
	input  logic [spce_pkg::VID_W-1:0]         arc_from,
	input  logic [spce_pkg::VID_W-1:0]         arc_to,
	input  logic [spce_pkg::ARC_COST_W-1:0]    arc_cost,
	input  logic [spce_pkg::VID_W-1:0]         query_from,
	input  logic [spce_pkg::VID_W-1:0]         query_to,
	output logic                               done,
	output logic                               path_found,
	output logic [spce_pkg::OUT_COST_W-1:0]    min_cost,
	output logic [spce_pkg::WAYS_W-1:0]        way_count,
	output logic                               arc_overflow,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [spce_pkg::CFG_W-1:0]         cfg_data
);
	import spce_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;
	logic       ctl_start;

	assign cfg_ready = 1'b1;
	assign ctl_start = start && !busy;

	spce_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctl_start),
		.op     (op),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	spce_dp #(
		.MAX_VERTICES (MAX_VERTICES),
		.MAX_ARCS     (MAX_ARCS),
		.COST_BITS    (COST_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_data     (cfg_data),
		.arc_from     (arc_from),
		.arc_to       (arc_to),
		.arc_cost     (arc_cost),
		.query_from   (query_from),
		.query_to     (query_to),
		.path_found   (path_found),
		.min_cost     (min_cost),
		.way_count    (way_count),
		.arc_overflow (arc_overflow)
	);

`ifndef SYNTHESIS
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("result strobe outside a query");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("engine did not return to idle after a result");
	a_no_path: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !path_found) |-> (min_cost == '0 && way_count == '0))
		else $error("no-path result carries cost or ways");
	a_ways: assert property (@(posedge clk) disable iff (!arst_n)
		(done && path_found) |-> (way_count != '0))
		else $error("found path with zero ways");
`endif

endmodule

// ===== tb/spce_checker.sv =====
// Checker for the shortest-path counting engine: predicts each query answer and compares.
`timescale 1ns / 1ps
module spce_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic                            busy,
	input  logic [1:0]                      op,
	input  logic [spce_pkg::VID_W-1:0]      arc_from,
	input  logic [spce_pkg::VID_W-1:0]      arc_to,
	input  logic [spce_pkg::ARC_COST_W-1:0] arc_cost,
	input  logic [spce_pkg::VID_W-1:0]      query_from,
	input  logic [spce_pkg::VID_W-1:0]      query_to,
	input  logic                            done,
	input  logic                            path_found,
	input  logic [spce_pkg::OUT_COST_W-1:0] min_cost,
	input  logic [spce_pkg::WAYS_W-1:0]     way_count,
	input  logic                            arc_overflow,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [spce_pkg::CFG_W-1:0]      cfg_data,
	output int                              fail_count,
	output int                              pending
);
	import spce_pkg::*;

	localparam int unsigned ARC_CAP   = 4096;
	localparam int unsigned VERT_CAP  = 1024;
	localparam longint unsigned NO_COST = 64'hFFFF_FFFF_FFFF_FFFF;

	typedef struct {
		logic [VID_W-1:0]      src;
		logic [VID_W-1:0]      dst;
		logic [ARC_COST_W-1:0] w;
	} arc_t;

	typedef struct {
		logic                  found;
		logic [OUT_COST_W-1:0] cost;
		logic [WAYS_W-1:0]     ways;
		logic                  ovf;
	} answer_t;

	typedef struct {
		longint unsigned c;
		int unsigned     v;
	} front_t;

	arc_t             arc_store[$];
	answer_t          answers_due[$];
	logic [CFG_W-1:0] vertex_reg;
	logic             dropped_arc;

	function automatic int unsigned vertex_limit(logic [CFG_W-1:0] r);
		if (r == 0) return 1;
		if (r > VERT_CAP) return VERT_CAP;
		return 32'(r);
	endfunction

	// Dijkstra with the frontier popped in (cost, vertex) order; the search
	// ends as soon as the end vertex is settled.
	function automatic answer_t count_routes(int unsigned s, int unsigned e);
		answer_t         a;
		int unsigned     n;
		longint unsigned best [VERT_CAP];
		int unsigned     ways [VERT_CAP];
		bit              fixed [VERT_CAP];
		front_t          frontier[$];
		front_t          h;
		int              m;
		int unsigned     u, v;
		longint unsigned nc, sum;
		a.found = 0; a.cost = 0; a.ways = 0; a.ovf = dropped_arc;
		n = vertex_limit(vertex_reg);
		if (s >= n || e >= n) return a;
		for (int i = 0; i < VERT_CAP; i++) begin
			best[i] = NO_COST; ways[i] = 0; fixed[i] = 0;
		end
		best[s] = 0;
		ways[s] = 1;
		h.c = 0; h.v = s;
		frontier.insert(frontier.size(), h);
		while (frontier.size() > 0) begin
			m = 0;
			for (int i = 1; i < frontier.size(); i++)
				if (frontier[i].c < frontier[m].c ||
				    (frontier[i].c == frontier[m].c && frontier[i].v < frontier[m].v))
					m = i;
			h = frontier[m];
			frontier.delete(m);
			u = h.v;
			if (fixed[u]) continue;
			fixed[u] = 1;
			if (u == e) begin
				a.found = 1;
				a.cost = (best[u] > 64'hFF_FFFF) ? '1 : best[u][OUT_COST_W-1:0];
				a.ways = ways[u];
				return a;
			end
			foreach (arc_store[k]) begin
				if (arc_store[k].src != u) continue;
				v = 32'(arc_store[k].dst);
				if (v >= n) continue;
				nc = best[u] + arc_store[k].w;
				if (best[v] > nc) begin
					best[v] = nc;
					ways[v] = ways[u];
					h.c = nc; h.v = v;
					frontier.insert(frontier.size(), h);
				end else if (best[v] == nc) begin
					sum = longint'(ways[v]) + longint'(ways[u]);
					ways[v] = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
				end
			end
		end
		return a;
	endfunction

	task automatic report(string what, longint unsigned got, longint unsigned want);
		$display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		answer_t want;
		arc_t    a;
		if (!arst_n) begin
			vertex_reg  <= 1;
			dropped_arc <= 0;
			arc_store.delete();
			answers_due.delete();
			fail_count  = 0;
			pending     <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				vertex_reg <= cfg_data;
			if (start && !busy) begin
				case (op)
					OP_CLEAR: begin
						arc_store.delete();
						dropped_arc <= 0;
					end
					OP_ADD: begin
						if (arc_store.size() >= ARC_CAP) begin
							dropped_arc <= 1;
						end else begin
							a.src = arc_from; a.dst = arc_to; a.w = arc_cost;
							arc_store.insert(arc_store.size(), a);
						end
					end
					OP_QUERY: answers_due.insert(answers_due.size(),
						count_routes(32'(query_from), 32'(query_to)));
					default: ;
				endcase
			end
			if (done) begin
				if (answers_due.size() == 0) begin
					report("result with no query outstanding", 1, 0);
				end else begin
					want = answers_due.pop_front();
					if (path_found !== want.found) report("path_found", path_found, want.found);
					if (min_cost !== want.cost) report("min_cost", min_cost, want.cost);
					if (way_count !== want.ways) report("way_count", way_count, want.ways);
					if (arc_overflow !== want.ovf)
						report("arc_overflow", arc_overflow, want.ovf);
				end
			end
			pending <= answers_due.size();
		end
	end
endmodule

// ===== tb/testbench.sv =====
// Top of the testbench: drives requests and configuration, and gives the verdict.
`timescale 1ns / 1ps
module testbench;
	import spce_pkg::*;

	localparam logic [1:0] OP_UNUSED  = 2'd3;
	localparam int         IDLE_LIMIT = 40000000;

	logic                  clk = 0;
	logic                  arst_n = 0;
	logic                  start = 0;
	logic                  busy;
	logic [1:0]            op = OP_CLEAR;
	logic [VID_W-1:0]      arc_from = 0, arc_to = 0, query_from = 0, query_to = 0;
	logic [ARC_COST_W-1:0] arc_cost = 0;
	logic                  done, path_found, arc_overflow;
	logic [OUT_COST_W-1:0] min_cost;
	logic [WAYS_W-1:0]     way_count;
	logic                  cfg_valid = 0;
	logic                  cfg_ready;
	logic [CFG_W-1:0]      cfg_data = 0;
	int                    fail_count, pending;
	int                    idle_cycles = 0;
	int unsigned           n_now = 1;

	always #5 clk = ~clk;

	shortest_path_count_engine uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op),
		.arc_from(arc_from), .arc_to(arc_to), .arc_cost(arc_cost),
		.query_from(query_from), .query_to(query_to), .done(done),
		.path_found(path_found), .min_cost(min_cost), .way_count(way_count),
		.arc_overflow(arc_overflow), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	spce_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op),
		.arc_from(arc_from), .arc_to(arc_to), .arc_cost(arc_cost),
		.query_from(query_from), .query_to(query_to), .done(done),
		.path_found(path_found), .min_cost(min_cost), .way_count(way_count),
		.arc_overflow(arc_overflow), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_data(cfg_data), .fail_count(fail_count), .pending(pending)
	);

	// The watchdog only counts cycles in which no channel moves anything.
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Holds start high until the request is taken; start is left high so that
	// a following request can go out in the next cycle.
	task automatic issue(logic [1:0] o, logic [9:0] af, logic [9:0] at, logic [13:0] ac,
	                     logic [9:0] qf, logic [9:0] qt);
		start <= 1; op <= o;
		arc_from <= af; arc_to <= at; arc_cost <= ac;
		query_from <= qf; query_to <= qt;
		do @(posedge clk); while (busy);
	endtask

	task automatic add_arc(logic [9:0] af, logic [9:0] at, logic [13:0] ac);
		issue(OP_ADD, af, at, ac, $urandom, $urandom);
	endtask

	task automatic ask(logic [9:0] qf, logic [9:0] qt);
		issue(OP_QUERY, $urandom, $urandom, $urandom, qf, qt);
	endtask

	task automatic drain();
		start <= 0;
		@(negedge clk);
		while (pending != 0 || busy) @(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_vertices(logic [CFG_W-1:0] v);
		drain();
		cfg_valid <= 1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		n_now = (v == 0) ? 1 : (v > 1024) ? 1024 : v;
	endtask

	function automatic logic [9:0] pick_vertex();
		if ($urandom_range(0, 9) == 0) return $urandom;
		return $urandom_range(0, n_now - 1);
	endfunction

	function automatic logic [13:0] pick_cost();
		case ($urandom_range(0, 9))
			0:       return 0;
			1:       return 14'h3FFF;
			2, 3:    return $urandom;
			default: return $urandom_range(1, 4);
		endcase
	endfunction

	initial begin
		int burst_left = 0;
		int k;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Reset setting of one vertex: start equals end, out-of-range start, unused code.
		ask(0, 0);
		ask(1, 0);
		issue(OP_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom);

		set_vertices(6);
		add_arc(0, 1, 3);
		add_arc(0, 2, 1);
		add_arc(2, 1, 2);      // second route to vertex 1 at equal cost
		add_arc(1, 3, 0);      // zero-cost arc
		add_arc(3, 4, 14'h3FFF);
		add_arc(5, 1023, 7);   // endpoint beyond the vertex count
		add_arc(0, 2, 1);      // duplicate arc
		ask(0, 1);
		ask(0, 3);
		ask(0, 4);
		ask(4, 0);
		ask(0, 1023);
		ask(1023, 1023);
		issue(OP_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom);
		issue(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
		ask(0, 1);

		set_vertices(0);
		ask(0, 0);
		ask(0, 1);
		set_vertices(11'h7FF);
		add_arc(0, 1023, 5);
		ask(0, 1023);
		ask(1023, 1023);
		issue(OP_CLEAR, 0, 0, 0, 0, 0);

		// Two parallel arcs on every step of a long chain, so that the route
		// count to the far end saturates.
		set_vertices(34);
		for (int i = 0; i < 66; i++) add_arc(10'(i / 2), 10'(i / 2 + 1), 1);
		add_arc($urandom, $urandom, $urandom);
		ask(0, 33);
		ask(0, 2);
		ask(0, 0);
		issue(OP_CLEAR, 0, 0, 0, 0, 0);
		ask(0, 0);

		// Random phases, each under its own vertex count.
		for (int ph = 0; ph < 9; ph++) begin
			case ($urandom_range(0, 7))
				0:       set_vertices(0);
				1:       set_vertices(1024);
				2:       set_vertices(11'h7FF);
				3:       set_vertices($urandom);
				default: set_vertices($urandom_range(1, 12));
			endcase
			for (int i = 0; i < 90; i++) begin
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 30);
					k = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
					if (k > 0) begin
						start <= 0;
						repeat (k) @(posedge clk);
					end
				end
				burst_left--;
				k = $urandom_range(0, 99);
				if (k < 4)
					issue(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
				else if (k < 8)
					issue(OP_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom);
				else if (k < 65)
					add_arc(pick_vertex(), pick_vertex(), pick_cost());
				else
					ask(pick_vertex(), pick_vertex());
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule
